// ----- sv/xhci_bulk_trb_ring_producer_assert.svh -----
// Assertion macros for the bulk TRB ring producer.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef XHCI_BULK_TRB_RING_PRODUCER_ASSERT_SVH
`define XHCI_BULK_TRB_RING_PRODUCER_ASSERT_SVH
`ifndef SYNTH
`define BTRP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BTRP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BTRP_ASSERT(lbl, cond, msg)
`define BTRP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/btrp_pkg.sv -----
// Shared types, constants and state encodings of the bulk TRB ring producer.
// No dependencies.
`default_nettype none
package btrp_pkg;
    localparam int RING_SLOTS_MAX_DEF     = 256;
    localparam int CHUNK_BYTES_DEF        = 65536;
    localparam int MAX_TRANSFER_BYTES_DEF = 1048576;
    localparam int MAX_RESULTS            = 20;
    localparam int RES_CNT_W              = 5;

    localparam logic [31:0] CTL_CYCLE = 32'h1;
    localparam logic [31:0] CTL_ENT   = 32'h2;
    localparam logic [31:0] CTL_CHAIN = 32'h10;
    localparam logic [31:0] CTL_IOC   = 32'h20;
    localparam int TYPE_SHIFT      = 10;
    localparam int TD_SHIFT        = 17;
    localparam logic [4:0] TD_MAX  = 5'd31;
    localparam logic [31:0] CTL_NORMAL = 32'd1 << TYPE_SHIFT;
    localparam logic [31:0] CTL_EVENT  = 32'd7 << TYPE_SHIFT;
    localparam logic [63:0] EVENT_DATA_PARAM = 64'hdeadbeef;

    localparam logic [1:0] REG_RING_ENTRIES = 2'd0;
    localparam logic [1:0] REG_MAX_PACKET   = 2'd1;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] status;
        logic [31:0] ctrl;
        logic        final_trb;
    } trb_item_t;

    typedef struct packed {
        logic [8:0]  slot;
        logic [63:0] addr;
        logic [31:0] status;
        logic [31:0] ctrl;
        logic        link;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {F_IDLE, F_SPLIT, F_DIV, F_PUSH, F_EVENT} front_state_t;
    typedef enum logic [1:0] {B_TAKE, B_LINK, B_FINAL} back_state_t;
endpackage
`default_nettype wire

// ----- sv/btrp_fifo.sv -----
// Small register FIFO used between the front and back parts and at the output.
// Generic over its entry type; no package needed.
`default_nettype none
module btrp_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  T          wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);
    localparam int AW = $clog2(DEPTH);

    T mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= wdata;
    end
endmodule
`default_nettype wire

// ----- sv/btrp_front.sv -----
// Front part: splits a request at chunk boundaries and computes the TD size.
// Uses btrp_pkg; feeds TRB items into the item FIFO.
`default_nettype none
module btrp_front #(
    parameter int CHUNK_BYTES        = btrp_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_TRANSFER_BYTES = btrp_pkg::MAX_TRANSFER_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [63:0]       buffer_addr,
    input  wire logic [20:0]       transfer_length,
    input  wire logic [10:0]       mps_bytes,
    output logic                   item_push,
    output btrp_pkg::trb_item_t    item,
    input  wire logic              item_full
);
    import btrp_pkg::*;

    localparam int REM_W   = $clog2(MAX_TRANSFER_BYTES + 1);
    localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
    localparam int OFS_W   = $clog2(CHUNK_BYTES);

    front_state_t state_reg, state_next;
    logic [63:0]      cur_reg;
    logic [REM_W-1:0] rem_reg, rem_next, rem_in, div_reg;
    logic [REM_W-1:0] chunk_reg, chunk_sel, room, shifted;
    logic [4:0]       td_reg;
    logic [2:0]       step_reg;
    logic [REM_W-1:0] mps;
    logic [31:0]      len_sat;
    logic             accept;

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;
    assign mps    = (mps_bytes == '0) ? REM_W'(1) : REM_W'(mps_bytes);
    assign len_sat = ({11'b0, transfer_length} > 32'(MAX_TRANSFER_BYTES))
                     ? 32'(MAX_TRANSFER_BYTES) : {11'b0, transfer_length};
    assign rem_in  = len_sat[REM_W-1:0];
    assign room    = REM_W'(CHUNK_W'(CHUNK_BYTES) - CHUNK_W'(cur_reg[OFS_W-1:0]));
    assign chunk_sel = (room < rem_reg) ? room : rem_reg;
    assign rem_next  = rem_reg - chunk_sel;
    assign shifted   = mps << step_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = (rem_in == '0) ? F_EVENT : F_SPLIT;
            F_SPLIT:
                state_next = (rem_next >= (mps << 5)) ? F_PUSH : F_DIV;
            F_DIV:
                if (step_reg == 3'd0)
                    state_next = F_PUSH;
            F_PUSH:
                if (!item_full)
                    state_next = (rem_reg == '0) ? F_EVENT : F_SPLIT;
            F_EVENT:
                if (!item_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        item      = '0;
        item_push = 1'b0;
        unique case (state_reg)
            F_PUSH:
            begin
                item_push   = 1'b1;
                item.addr   = cur_reg;
                item.status = (32'(td_reg) << TD_SHIFT) | (32'(chunk_reg) & 32'h1FFFF);
                item.ctrl   = CTL_NORMAL | CTL_CHAIN | ((rem_reg != '0) ? CTL_ENT : 32'h0);
            end
            F_EVENT:
            begin
                item_push      = 1'b1;
                item.addr      = EVENT_DATA_PARAM;
                item.ctrl      = CTL_EVENT | CTL_IOC;
                item.final_trb = 1'b1;
            end
            default:
                item_push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Restoring division of the remaining bytes, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                cur_reg <= buffer_addr;
                rem_reg <= rem_in;
            end
            F_SPLIT:
            begin
                chunk_reg <= chunk_sel;
                rem_reg   <= rem_next;
                div_reg   <= rem_next;
                td_reg    <= (rem_next >= (mps << 5)) ? TD_MAX : 5'd0;
                step_reg  <= 3'd4;
            end
            F_DIV:
            begin
                if (div_reg >= shifted)
                begin
                    div_reg <= div_reg - shifted;
                    td_reg[step_reg] <= 1'b1;
                end
                step_reg <= step_reg - 3'd1;
            end
            F_PUSH:
                if (!item_full)
                    cur_reg <= cur_reg + 64'(chunk_reg);
            default:
                cur_reg <= cur_reg;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/btrp_back.sv -----
// Back part: places TRB items on the ring, stamps cycle bits, adds link updates.
// Uses btrp_pkg and the assertion header; writes into the result FIFO.
`default_nettype none
module btrp_back #(
    parameter int RING_SLOTS_MAX = btrp_pkg::RING_SLOTS_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [8:0]        ring_entries,
    input  btrp_pkg::trb_item_t    item,
    input  wire logic              item_empty,
    output logic                   item_pop,
    output logic                   res_push,
    output btrp_pkg::result_t      res,
    input  wire logic              res_full
);
    import btrp_pkg::*;
`include "xhci_bulk_trb_ring_producer_assert.svh"

    localparam int ENT_W = $clog2(RING_SLOTS_MAX + 1);

    back_state_t state_reg, state_next;
    logic [ENT_W-1:0]     idx_reg, eff;
    logic [ENT_W:0]       idx_inc;
    logic                 cycle_reg, drop_reg, hold_vld_reg, link_chain_reg, link_final_reg;
    logic [RES_CNT_W-1:0] n_reg;
    result_t              hold_reg, new_res;
    logic                 wrap, fits, can_emit, emit;
    logic [31:0]          ent_ext;
    logic [31:0]          wctrl;

    assign ent_ext = (ring_entries == '0) ? 32'd1 :
                     ((32'(ring_entries) > 32'(RING_SLOTS_MAX)) ? 32'(RING_SLOTS_MAX)
                                                                : 32'(ring_entries));
    assign eff      = ent_ext[ENT_W-1:0];
    assign idx_inc  = (ENT_W+1)'(idx_reg) + 1'b1;
    assign wrap     = idx_inc >= (ENT_W+1)'(eff);
    assign fits     = ((RES_CNT_W+1)'(n_reg) + (wrap ? 6'd2 : 6'd1))
                      <= (RES_CNT_W+1)'(MAX_RESULTS);
    assign can_emit = !hold_vld_reg || !res_full;
    assign wctrl    = (item.ctrl & ~CTL_CYCLE) | {31'b0, cycle_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_TAKE:
                if (!item_empty)
                begin
                    if (drop_reg || !fits)
                    begin
                        if (item.final_trb)
                            state_next = B_FINAL;
                    end
                    else if (can_emit)
                    begin
                        if (wrap)
                            state_next = B_LINK;
                        else if (item.final_trb)
                            state_next = B_FINAL;
                    end
                end
            B_LINK:
                if (can_emit)
                    state_next = link_final_reg ? B_FINAL : B_TAKE;
            B_FINAL:
                if (!res_full)
                    state_next = B_TAKE;
            default:
                state_next = B_TAKE;
        endcase
    end

    always_comb
    begin
        item_pop = 1'b0;
        emit     = 1'b0;
        new_res  = '0;
        res_push = 1'b0;
        res      = hold_reg;
        res.last = 1'b0;
        unique case (state_reg)
            B_TAKE:
                if (!item_empty)
                begin
                    if (drop_reg || !fits)
                        item_pop = 1'b1;
                    else if (can_emit)
                    begin
                        item_pop       = 1'b1;
                        emit           = 1'b1;
                        new_res.slot   = 9'(idx_reg);
                        new_res.addr   = item.addr;
                        new_res.status = item.status;
                        new_res.ctrl   = wctrl;
                    end
                end
            B_LINK:
                if (can_emit)
                begin
                    emit         = 1'b1;
                    new_res.slot = 9'(eff);
                    new_res.ctrl = {31'b0, cycle_reg} | (link_chain_reg ? CTL_CHAIN : 32'h0);
                    new_res.link = 1'b1;
                end
            B_FINAL:
            begin
                res_push = 1'b1;
                res.last = 1'b1;
            end
            default:
                item_pop = 1'b0;
        endcase
        if (emit && hold_vld_reg)
            res_push = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_TAKE;
            idx_reg      <= '0;
            cycle_reg    <= 1'b1;
            drop_reg     <= 1'b0;
            hold_vld_reg <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                hold_vld_reg <= 1'b1;
                n_reg        <= n_reg + 1'b1;
            end
            unique case (state_reg)
                B_TAKE:
                    if (!item_empty)
                    begin
                        if (drop_reg || !fits)
                            drop_reg <= !item.final_trb;
                        else if (can_emit && !wrap)
                            idx_reg <= idx_inc[ENT_W-1:0];
                    end
                B_LINK:
                    if (can_emit)
                    begin
                        cycle_reg <= !cycle_reg;
                        idx_reg   <= '0;
                    end
                B_FINAL:
                    if (!res_full)
                    begin
                        hold_vld_reg <= 1'b0;
                        n_reg        <= '0;
                        drop_reg     <= 1'b0;
                    end
                default:
                    drop_reg <= drop_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            hold_reg <= new_res;
        if (state_reg == B_TAKE && item_pop && emit)
        begin
            link_chain_reg <= (wctrl & CTL_CHAIN) != 32'h0;
            link_final_reg <= item.final_trb;
        end
    end

    `BTRP_ASSERT(a_budget, n_reg <= RES_CNT_W'(MAX_RESULTS), "result budget exceeded")
    `BTRP_ASSERT_IMPL(a_link_held, state_reg == B_LINK, hold_vld_reg, "link without held write")
    `BTRP_ASSERT_IMPL(a_final_held, state_reg == B_FINAL, hold_vld_reg, "run ends with no result")
    `BTRP_ASSERT_IMPL(a_wrap_zero, state_reg == B_LINK && can_emit, ##1 idx_reg == '0,
                      "index not wrapped after link")
endmodule
`default_nettype wire

// ----- sv/xhci_bulk_trb_ring_producer.sv -----
// Top level of the bulk TRB ring producer: config registers, front, FIFOs, back.
// Depends on btrp_pkg, btrp_fifo, btrp_front and btrp_back.
//
// Usage: a request (buffer_addr, transfer_length) is pushed while full is low.
// It is cut into Normal TRBs at every chunk boundary and closed by an Event
// Data TRB with IOC. Each ring write, and each link TRB update on a ring wrap,
// is one result beat on the output queue; last_of_run marks a run's final beat.
// Results are read by pop while empty is low; a stalled reader leaves them
// queued, and the back part stops once the result queue fills.
// Flow: the front accepts a request in its idle state, then per Normal TRB
// runs a split state, a five step divider for the TD size (skipped when the
// TD size saturates) and a hand-off state, plus a hand-off for the Event Data
// TRB. Only the last two TRBs can need the divider. The back handles each
// write, each link update and the closing of the run in turn.
// The next request is accepted once the front has handed off the last item.
// Reset clears the ring index, sets the cycle bit, empties both queues and
// restores ring_entries to 256 and the max packet size to 512.
// Configuration writes are always accepted (cfg_ready is tied high).
`default_nettype none
module xhci_bulk_trb_ring_producer #(
    parameter int RING_SLOTS_MAX     = btrp_pkg::RING_SLOTS_MAX_DEF,
    parameter int CHUNK_BYTES        = btrp_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_TRANSFER_BYTES = btrp_pkg::MAX_TRANSFER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] buffer_addr,
    input  wire logic [20:0] transfer_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [8:0]       slot_index,
    output logic [63:0]      trb_address,
    output logic [31:0]      trb_status,
    output logic [31:0]      trb_control,
    output logic             is_link_update,
    output logic             last_of_run
);
    import btrp_pkg::*;

    logic [8:0]  ring_entries_reg;
    logic [10:0] max_packet_reg;
    trb_item_t   fr_item, bk_item;
    logic        fr_push, iq_full, iq_empty, bk_pop;
    result_t     bk_res, out_res;
    logic        bk_push, oq_full;

    assign cfg_ready = 1'b1;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_entries_reg <= 9'd256;
            max_packet_reg   <= 11'd512;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_RING_ENTRIES)
                ring_entries_reg <= cfg_data[8:0];
            else if (cfg_index == REG_MAX_PACKET)
                max_packet_reg <= cfg_data;
        end
    end

    btrp_front #(
        .CHUNK_BYTES        (CHUNK_BYTES),
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .buffer_addr     (buffer_addr),
        .transfer_length (transfer_length),
        .mps_bytes       (max_packet_reg),
        .item_push       (fr_push),
        .item            (fr_item),
        .item_full       (iq_full)
    );

    btrp_fifo #(.T(trb_item_t), .DEPTH(4)) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_item),
        .full  (iq_full),
        .pop   (bk_pop),
        .rdata (bk_item),
        .empty (iq_empty)
    );

    btrp_back #(.RING_SLOTS_MAX(RING_SLOTS_MAX)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ring_entries (ring_entries_reg),
        .item         (bk_item),
        .item_empty   (iq_empty),
        .item_pop     (bk_pop),
        .res_push     (bk_push),
        .res          (bk_res),
        .res_full     (oq_full)
    );

    btrp_fifo #(.T(result_t), .DEPTH(4)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .wdata (bk_res),
        .full  (oq_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign slot_index     = out_res.slot;
    assign trb_address    = out_res.addr;
    assign trb_status     = out_res.status;
    assign trb_control    = out_res.ctrl;
    assign is_link_update = out_res.link;
    assign last_of_run    = out_res.last;
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for xhci_bulk_trb_ring_producer: drives bulk requests and
// register writes, predicts every ring write and link update, compares per field.
// Depends on btrp_pkg and the RTL of the producer.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import btrp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_RING_ENTRIES;
    logic [10:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] buffer_addr = '0;
    logic [20:0] transfer_length = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [8:0]  slot_index;
    logic [63:0] trb_address;
    logic [31:0] trb_status;
    logic [31:0] trb_control;
    logic        is_link_update;
    logic        last_of_run;

    xhci_bulk_trb_ring_producer u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .buffer_addr(buffer_addr), .transfer_length(transfer_length),
        .empty(empty), .pop(pop),
        .slot_index(slot_index), .trb_address(trb_address),
        .trb_status(trb_status), .trb_control(trb_control),
        .is_link_update(is_link_update), .last_of_run(last_of_run)
    );

    // Two half-period delays give the 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the producer: registers and ring position.
    logic [8:0]  ring_entries_q;
    logic [10:0] max_packet_q;
    logic [8:0]  ring_pos;
    logic        cycle_bit;

    result_t expected_writes[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          feeding_done = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    // Directed table: a row holds only an address and a length, and every row
    // uses the predictor; only the first request after reset is expected by hand.
    typedef struct {
        logic [63:0] addr;
        logic [20:0] len;
    } request_t;

    // Appends one ring write plus, on a wrap, its link update; returns 0 when the beat
    // budget of one request would be exceeded.
    function automatic bit ring_write(ref result_t run[$], input logic [63:0] addr,
                                      input logic [31:0] status, input logic [31:0] ctrl);
        logic [8:0]  size;
        logic [9:0]  next_pos;
        bit          wraps;
        result_t     beat;
        size = (ring_entries_q == 0) ? 9'd1 :
               (ring_entries_q > 9'd256) ? 9'd256 : ring_entries_q;
        next_pos = ring_pos + 10'd1;
        wraps = next_pos >= size;
        if (run.size() + (wraps ? 2 : 1) > MAX_RESULTS)
            return 1'b0;
        ctrl = (ctrl & ~CTL_CYCLE) | {31'd0, cycle_bit};
        beat = '{slot: ring_pos, addr: addr, status: status, ctrl: ctrl,
                 link: 1'b0, last: 1'b0};
        run.push_back(beat);
        if (wraps)
        begin
            beat = '{slot: size, addr: 64'd0, status: 32'd0,
                     ctrl: (ctrl & CTL_CHAIN) | {31'd0, cycle_bit},
                     link: 1'b1, last: 1'b0};
            run.push_back(beat);
            cycle_bit = ~cycle_bit;
            ring_pos = 9'd0;
        end
        else
            ring_pos = next_pos[8:0];
        return 1'b1;
    endfunction

    // Splits one request into Normal TRBs and the closing Event Data TRB.
    task automatic predict_request(input logic [63:0] start, input logic [20:0] len);
        result_t     run[$];
        logic [63:0] cursor;
        logic [31:0] left;
        logic [31:0] room;
        logic [31:0] piece;
        logic [31:0] divisor;
        logic [31:0] td;
        logic [31:0] ctrl;
        bit          fits;
        cursor = start;
        left = (len > 21'd1048576) ? 32'd1048576 : {11'd0, len};
        divisor = (max_packet_q == 0) ? 32'd1 : {21'd0, max_packet_q};
        fits = 1'b1;
        while (left > 0 && fits)
        begin
            room = 32'd65536 - {16'd0, cursor[15:0]};
            piece = (room < left) ? room : left;
            left -= piece;
            td = left / divisor;
            if (td > 31) td = 31;
            ctrl = CTL_NORMAL | CTL_CHAIN | ((left > 0) ? CTL_ENT : 32'd0);
            fits = ring_write(run, cursor, (td << TD_SHIFT) | (piece & 32'h1FFFF), ctrl);
            cursor += {32'd0, piece};
        end
        if (fits)
            void'(ring_write(run, EVENT_DATA_PARAM, 32'd0, CTL_EVENT | CTL_IOC));
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_writes.push_back(run[i]);
    endtask

    // Sends one request beat after a random gap and predicts its writes.
    // With no gap, push simply stays high into the next beat.
    task automatic send_request(input logic [63:0] addr, input logic [20:0] len);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        buffer_addr <= addr;
        transfer_length <= len;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_request(addr, len);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_register(input logic [1:0] index, input logic [10:0] value);
        push <= 1'b0;
        while (expected_writes.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_RING_ENTRIES) ring_entries_q = value[8:0];
        else max_packet_q = value;
    endtask

    function automatic logic [20:0] random_length();
        case ($urandom_range(0, 9))
            0: return 21'd0;
            1: return 21'($urandom_range(1, 16));
            2: return 21'($urandom_range(1048577, 2097151));
            3: return 21'($urandom_range(0, 1048576));
            4: return 21'd1048576;
            default: return 21'($urandom_range(1, 200000));
        endcase
    endfunction

    function automatic logic [63:0] random_address();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: a[15:0] = 16'hFFFF - 16'($urandom_range(0, 64));
            1: a = 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 65535));
            default: ;
        endcase
        return a;
    endfunction

    // Stimulus.
    initial
    begin
        request_t directed[$];
        logic [10:0] mps_list[5];
        logic [10:0] ring_list[6];
        ring_entries_q = 9'd256;
        max_packet_q = 11'd512;
        ring_pos = 9'd0;
        cycle_bit = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The very first request after reset: a single Event Data TRB at slot
        // 0, cycle set, IOC and type 7, flagged as the last beat.
        push <= 1'b1;
        buffer_addr <= 64'd0;
        transfer_length <= 21'd0;
        @(posedge clk);
        while (full) @(posedge clk);
        expected_writes.push_back('{slot: 9'd0, addr: EVENT_DATA_PARAM, status: 32'd0,
                                   ctrl: CTL_EVENT | CTL_IOC | CTL_CYCLE,
                                   link: 1'b0, last: 1'b1});
        ring_pos = 9'd1;

        directed = '{
            '{64'd0, 21'd1},
            '{64'hFFFF_FFFF_FFFF_FFFF, 21'd2},        // address wraps to zero
            '{64'h0000_0000_0001_FFF0, 21'd64},       // crosses a chunk boundary
            '{64'h1234_5678_0000_0000, 21'd65536},
            '{64'hA5A5_A5A5_5A5A_5A5A, 21'd1048576},  // largest transfer
            '{64'h0, 21'h1FFFFF},                     // saturated length
            '{64'h5555_5555_5555_5555, 21'h0AAAAA},
            '{64'hAAAA_AAAA_AAAA_AAAA, 21'h155555},
            '{64'h8000_0000_0000_8000, 21'd131072}
        };
        foreach (directed[i])
            send_request(directed[i].addr, directed[i].len);

        // Tiny rings, shrinking below the current index, max packet extremes.
        write_register(REG_RING_ENTRIES, 11'd0);
        write_register(REG_MAX_PACKET, 11'd0);
        send_request(64'h10, 21'd300000);
        write_register(REG_RING_ENTRIES, 11'd1);
        write_register(REG_MAX_PACKET, 11'd2047);
        send_request(64'hFFF0, 21'd70000);
        write_register(REG_RING_ENTRIES, 11'd511);
        write_register(REG_MAX_PACKET, 11'd1);
        send_request(64'h0, 21'd900000);
        send_request(64'h0, 21'd5);

        ring_list = '{11'd256, 11'd2, 11'd7, 11'd1, 11'd300, 11'd33};
        mps_list = '{11'd512, 11'd1024, 11'd8, 11'd64, 11'd1};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(REG_RING_ENTRIES, ring_list[phase]);
            write_register(REG_MAX_PACKET, mps_list[phase % 5]);
            for (int k = 0; k < 75; k++)
                send_request(random_address(), random_length());
        end
        push <= 1'b0;
        feeding_done = 1'b1;
    end

    // Reader: random pops, compare the beat with the oldest expectation.
    initial
    begin
        int stall;
        result_t want;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (expected_writes.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected beat: slot %0d addr %h", slot_index, trb_address);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (want != {slot_index, trb_address, trb_status, trb_control,
                             is_link_update, last_of_run})
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("mismatch: exp slot %0d addr %h st %h ctl %h lnk %b last %b",
                                 want.slot, want.addr, want.status, want.ctrl, want.link,
                                 want.last);
                        $display("          got slot %0d addr %h st %h ctl %h lnk %b last %b",
                                 slot_index, trb_address, trb_status, trb_control,
                                 is_link_update, last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // End of run: drain, then let any stray beat show up.
    initial
    begin
        wait (feeding_done);
        wait (expected_writes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_writes.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
